// ----- hdl/blr_pkg.sv -----
// Shared constants and controller/datapath interface types for the line rasterizer.
package blr_pkg;

  localparam int COORD_BITS    = 6;
  localparam int DBL_BITS      = COORD_BITS + 2;
  localparam int ERR_BITS      = COORD_BITS + 3;
  localparam int PITCH_BITS    = COORD_BITS + 1;
  localparam int ADDR_BITS     = 2 * COORD_BITS;
  localparam int PROD_BITS     = COORD_BITS + PITCH_BITS;
  localparam int IN_FIELD_BITS = 4 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(64);

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_end;
    logic slot_free;
  } dp_status_t;

endpackage

// ----- hdl/blr_ctrl.sv -----
// Controller state machine: takes a request, then sequences one pixel per free output slot.
module blr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  blr_pkg::dp_status_t status,
  output blr_pkg::ctrl_cmd_t  cmd
);
  import blr_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == IDLE);
  assign cmd.load  = in_tvalid && in_tready;
  assign cmd.emit  = (state_r == RUN) && status.slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      IDLE: begin
        if (cmd.load) begin
          state_nxt = RUN;
        end
      end
      RUN: begin
        if (cmd.emit && status.at_end) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> state_r == RUN)
    else $error("pixel emitted outside a line");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.at_end) |=> in_tready)
    else $error("controller did not return to idle after end pixel");

  a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == RUN && !in_tready)
    else $error("controller did not start a line after request");

endmodule

// ----- hdl/blr_datapath.sv -----
// Datapath: line setup, error-term stepping, pixel address and output register.
module blr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [blr_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input  logic                               cfg_wr_en,
  input  logic [blr_pkg::PITCH_BITS-1:0]     cfg_wr_data,
  input  blr_pkg::ctrl_cmd_t                 cmd,
  output blr_pkg::dp_status_t                status,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [blr_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                               out_tlast
);
  import blr_pkg::*;

  logic [PITCH_BITS-1:0]      row_pitch_r;
  logic [COORD_BITS-1:0]      cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic [DBL_BITS-1:0]        dbl_dx_r, dbl_dy_r;
  logic                       sx_neg_r, sy_neg_r, x_major_r;

  logic [COORD_BITS-1:0]      start_x, start_y, end_x, end_y;
  logic signed [COORD_BITS:0] dx_s, dy_s;
  logic [COORD_BITS:0]        dx_mag, dy_mag;
  logic [COORD_BITS-1:0]      dx_abs, dy_abs;
  logic [DBL_BITS-1:0]        dbl_dx, dbl_dy;
  logic                       x_major;
  logic signed [ERR_BITS-1:0] err_init;

  logic                       minor_step;
  logic [DBL_BITS-1:0]        dbl_major, dbl_minor;
  logic signed [ERR_BITS-1:0] err_nxt;
  logic [COORD_BITS-1:0]      x_stepped, y_stepped, cur_x_nxt, cur_y_nxt;

  logic [PROD_BITS-1:0]       addr_prod;
  logic [ADDR_BITS-1:0]       addr;

  logic                       out_valid_r;
  logic [COORD_BITS-1:0]      out_x_r, out_y_r;
  logic [ADDR_BITS-1:0]       out_addr_r;
  logic                       out_last_r;

  // request setup
  assign start_x = in_tdata[COORD_BITS-1:0];
  assign start_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign end_x   = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign end_y   = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign dx_s   = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy_s   = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  assign dx_mag = dx_s[COORD_BITS] ? -dx_s : dx_s;
  assign dy_mag = dy_s[COORD_BITS] ? -dy_s : dy_s;
  assign dx_abs = dx_mag[COORD_BITS-1:0];
  assign dy_abs = dy_mag[COORD_BITS-1:0];
  assign dbl_dx = {1'b0, dx_abs, 1'b0};
  assign dbl_dy = {1'b0, dy_abs, 1'b0};
  assign x_major = dbl_dx > dbl_dy;
  assign err_init = x_major ? $signed(ERR_BITS'(dbl_dy) - ERR_BITS'(dx_abs))
                            : $signed(ERR_BITS'(dbl_dx) - ERR_BITS'(dy_abs));

  // pixel stepping
  assign minor_step = !err_r[ERR_BITS-1];
  assign dbl_major  = x_major_r ? dbl_dx_r : dbl_dy_r;
  assign dbl_minor  = x_major_r ? dbl_dy_r : dbl_dx_r;
  assign err_nxt    = err_r + $signed(ERR_BITS'(dbl_minor))
                      - (minor_step ? $signed(ERR_BITS'(dbl_major)) : '0);
  assign x_stepped  = sx_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
  assign y_stepped  = sy_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
  assign cur_x_nxt  = (x_major_r || minor_step) ? x_stepped : cur_x_r;
  assign cur_y_nxt  = (!x_major_r || minor_step) ? y_stepped : cur_y_r;

  assign status.at_end    = x_major_r ? (cur_x_r == end_x_r) : (cur_y_r == end_y_r);
  assign status.slot_free = !out_valid_r || out_tready;

  assign addr_prod = PROD_BITS'(cur_y_r) * PROD_BITS'(row_pitch_r);
  assign addr      = ADDR_BITS'(addr_prod + PROD_BITS'(cur_x_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r <= PITCH_RESET;
    end else if (cfg_wr_en) begin
      row_pitch_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r   <= start_x;
      cur_y_r   <= start_y;
      end_x_r   <= end_x;
      end_y_r   <= end_y;
      dbl_dx_r  <= dbl_dx;
      dbl_dy_r  <= dbl_dy;
      sx_neg_r  <= dx_s[COORD_BITS];
      sy_neg_r  <= dy_s[COORD_BITS];
      x_major_r <= x_major;
      err_r     <= err_init;
    end else if (cmd.emit && !status.at_end) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r    <= cur_x_r;
      out_y_r    <= cur_y_r;
      out_addr_r <= addr;
      out_last_r <= status.at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'({out_addr_r, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted pixel not presented");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.at_end) |=> out_tlast)
    else $error("end pixel not flagged last");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("output register overwritten while held");

endmodule

// ----- hdl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: controller plus datapath.
//
//  channel  | ports              | payload
//  ---------+--------------------+-------------------------------------------------
//  request  | in_tvalid/tready   | in_tdata: start_x, start_y, end_x, end_y
//  pixel    | out_tvalid/tready  | out_tdata: pixel_x, pixel_y, pixel_address;
//           |                    | out_tlast: last_pixel
//  config   | cfg_wr_en          | cfg_wr_data: row_pitch
//
// A request is loaded into the setup registers, then the error-term step loop gives one pixel
// per cycle while the output slot is free; the next request can be taken in the cycle after
// the end pixel is emitted into the output register. Output stalls hold the loop.
// Reset returns the block to idle with row_pitch at 64.
module bresenham_line_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [blr_pkg::IN_DATA_BITS-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x, pixel_y, pixel_address
  output logic [blr_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [blr_pkg::PITCH_BITS-1:0]     cfg_wr_data
);
  import blr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  blr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  blr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
